>>> sv/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Types and constants shared by the scanline timing and affine reference
// block.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int unsigned VISIBLE_LINES = 160;
    localparam int unsigned TOTAL_LINES   = 228;

    localparam logic [7:0] LINE_VIS   = 8'(VISIBLE_LINES);
    localparam logic [7:0] LINE_LAST  = 8'(TOTAL_LINES - 1);
    localparam logic [7:0] LINE_WRAP  = 8'(TOTAL_LINES);
    localparam logic [7:0] DMA3_FIRST = 8'd2;
    localparam logic [7:0] DMA3_LAST  = 8'(VISIBLE_LINES + 2);

    localparam logic [9:0] DRAW_CYCLES  = 10'd1006;
    localparam logic [9:0] BLANK_CYCLES = 10'd226;

    localparam int unsigned REF_W      = 28;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned NUM_REFS   = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [STEP_W-1:0] STEP_X_RESET = 16'd0;
    localparam logic [STEP_W-1:0] STEP_Y_RESET = 16'd256;

    localparam logic OP_PERIOD_END = 1'b0;
    localparam logic OP_REF_WRITE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LINE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG2_DX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG2_DY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG3_DX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG3_DY     = 3'd5;

    localparam int unsigned FLAG_VBLANK = 0;
    localparam int unsigned FLAG_HBLANK = 1;
    localparam int unsigned FLAG_MATCH  = 2;

    localparam int unsigned EV_HDMA   = 0;
    localparam int unsigned EV_VBLANK = 1;
    localparam int unsigned EV_DMA3   = 2;
    localparam int unsigned EV_FRAME  = 3;

    typedef struct packed {
        logic        op;
        logic [1:0]  ref_select;
        logic        hi_half;
        logic [15:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]              line;
        logic [2:0]              status_flags;
        logic [2:0]              irq_pulses;
        logic [3:0]              events;
        logic [9:0]              period_cycles;
        logic signed [REF_W-1:0] bg2_ref_x;
        logic signed [REF_W-1:0] bg2_ref_y;
        logic signed [REF_W-1:0] bg3_ref_x;
        logic signed [REF_W-1:0] bg3_ref_y;
    } t_out_word;

    typedef struct packed {
        logic [7:0] line;
        logic [2:0] status_flags;
        logic [2:0] irq_pulses;
        logic [3:0] events;
        logic [9:0] period_cycles;
    } t_tim_res;

    typedef struct packed {
        logic write;
        logic step;
        logic reload;
    } t_ref_ctl;

endpackage

>>> sv/slt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_if
// Handshake channels: input words, result words and register writes.
// ----------------------------------------------------------------------------
interface slt_in_if;
    logic              valid;
    logic              ready;
    slt_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slt_out_if;
    logic               valid;
    logic               ready;
    slt_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [slt_pkg::CFG_IDX_W-1:0]    index;
    logic [slt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/scanline_timing_and_affine_refs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_timing_and_affine_refs
// Display line timing with status flags, interrupt pulses, DMA events and
// four affine reference accumulators.
// ----------------------------------------------------------------------------
// Channels: i_in takes one word per handshake, either a period-end event or
// a reference half write; o_out gives exactly one result word per input
// word. i_cfg writes the six registers (index 0..5; higher indexes are
// ignored) and is always ready outside reset; write only while idle.
// Output: each result is registered in the result register, or in the
// skid stage while o_out stalls. Throughput: one word per cycle unless
// the skid stage is full; state, flags and accumulators update on acceptance.
// Stall: a result register plus a one-word skid stage; i_in stays ready
// while one result waits and drops only when both are full.
// Reset: synchronous, active low; line 0, draw period, flags clear, all
// accumulators and latched references zero, steps 0/256/0/256. Ready is low
// while reset is held; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scanline_timing_and_affine_refs (
    input  logic   i_clk,
    input  logic   i_rst_n,
    slt_in_if.sink  i_in,
    slt_cfg_if.sink i_cfg,
    slt_out_if.source o_out
);
    import slt_pkg::*;

    logic                           acc;
    logic                           cfg_wr;
    t_tim_res                       tim_res;
    t_ref_ctl                       ref_ctl;
    logic [NUM_REFS-1:0][REF_W-1:0] refs;
    t_out_word                      res;
    logic                           buf_ready;

    assign acc         = i_in.valid && buf_ready;
    assign i_in.ready  = buf_ready;
    assign i_cfg.ready = i_rst_n;
    assign cfg_wr      = i_cfg.valid && i_rst_n;

    slt_timing u_timing (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_word     (i_in.data),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .o_res      (tim_res),
        .o_ctl      (ref_ctl)
    );

    slt_refs u_refs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_word     (i_in.data),
        .i_ctl      (ref_ctl),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .o_ref      (refs)
    );

    always_comb begin
        res.line          = tim_res.line;
        res.status_flags  = tim_res.status_flags;
        res.irq_pulses    = tim_res.irq_pulses;
        res.events        = tim_res.events;
        res.period_cycles = tim_res.period_cycles;
        res.bg2_ref_x     = $signed(refs[0]);
        res.bg2_ref_y     = $signed(refs[1]);
        res.bg3_ref_x     = $signed(refs[2]);
        res.bg3_ref_y     = $signed(refs[3]);
    end

    slt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_word  (res),
        .o_ready (buf_ready),
        .o_valid (o_out.valid),
        .o_word  (o_out.data),
        .i_ready (o_out.ready)
    );

endmodule

>>> sv/slt_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_timing
// Period and line sequencing, status flags, interrupt pulses and events.
// ----------------------------------------------------------------------------
module slt_timing (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_acc,
    input  slt_pkg::t_in_word                i_word,
    input  logic                             i_cfg_wr,
    input  logic [slt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output slt_pkg::t_tim_res                o_res,
    output slt_pkg::t_ref_ctl                o_ctl
);
    import slt_pkg::*;

    logic       r_blank, n_blank;
    logic [7:0] r_line,  n_line;
    logic [2:0] r_flags, n_flags;
    logic [2:0] r_irq_en;
    logic [7:0] r_match;

    logic [7:0] line_inc;
    logic       match_inc;
    logic       match_zero;
    logic [2:0] irq;
    logic [3:0] ev;
    logic [9:0] cyc;
    t_ref_ctl   ctl;

    assign line_inc   = r_line + 8'd1;
    assign match_inc  = (line_inc == r_match);
    assign match_zero = (r_match == 8'd0);

    always_comb begin
        n_blank = r_blank;
        n_line  = r_line;
        n_flags = r_flags;
        irq     = '0;
        ev      = '0;
        cyc     = '0;
        ctl     = '0;
        if (i_word.op == OP_REF_WRITE) begin
            ctl.write = 1'b1;
        end else if (!r_blank) begin
            n_blank              = 1'b1;
            n_flags[FLAG_HBLANK] = 1'b1;
            irq[FLAG_HBLANK]     = r_irq_en[FLAG_HBLANK];
            ev[EV_HDMA]          = (r_line < LINE_VIS);
            cyc                  = BLANK_CYCLES;
        end else begin
            n_blank              = 1'b0;
            n_line               = line_inc;
            ev[EV_DMA3]          = (line_inc >= DMA3_FIRST) && (line_inc <= DMA3_LAST);
            n_flags[FLAG_MATCH]  = match_inc;
            irq[FLAG_MATCH]      = r_irq_en[FLAG_MATCH] & match_inc;
            n_flags[FLAG_HBLANK] = 1'b0;
            if (line_inc < LINE_VIS) begin
                ctl.step = 1'b1;
            end else if (line_inc == LINE_VIS) begin
                n_flags[FLAG_VBLANK] = 1'b1;
                irq[FLAG_VBLANK]     = r_irq_en[FLAG_VBLANK];
                ev[EV_VBLANK]        = 1'b1;
            end else if (line_inc == LINE_LAST) begin
                n_flags[FLAG_VBLANK] = 1'b0;
            end else if (line_inc == LINE_WRAP) begin
                // frame wrap: second compare against line 0
                ctl.reload          = 1'b1;
                ev[EV_FRAME]        = 1'b1;
                n_line              = 8'd0;
                n_flags[FLAG_MATCH] = match_zero;
                irq[FLAG_MATCH]     = r_irq_en[FLAG_MATCH] & (match_inc | match_zero);
            end
            cyc = DRAW_CYCLES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank  <= 1'b0;
            r_line   <= 8'd0;
            r_flags  <= 3'd0;
            r_irq_en <= 3'd0;
            r_match  <= 8'd0;
        end else begin
            if (i_acc) begin
                r_blank <= n_blank;
                r_line  <= n_line;
                r_flags <= n_flags;
            end
            if (i_cfg_wr) begin
                case (i_cfg_idx)
                    CFG_IRQ_EN:     r_irq_en <= i_cfg_data[2:0];
                    CFG_MATCH_LINE: r_match  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_res.line          = n_line;
        o_res.status_flags  = n_flags;
        o_res.irq_pulses    = irq;
        o_res.events        = ev;
        o_res.period_cycles = cyc;
    end

    assign o_ctl = ctl;

endmodule

>>> sv/slt_refs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_refs
// Four affine reference accumulators with latched reload values and
// per-line signed steps.
// ----------------------------------------------------------------------------
module slt_refs (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_acc,
    input  slt_pkg::t_in_word                                   i_word,
    input  slt_pkg::t_ref_ctl                                   i_ctl,
    input  logic                                                i_cfg_wr,
    input  logic [slt_pkg::CFG_IDX_W-1:0]                       i_cfg_idx,
    input  logic [slt_pkg::CFG_DATA_W-1:0]                      i_cfg_data,
    output logic [slt_pkg::NUM_REFS-1:0][slt_pkg::REF_W-1:0]    o_ref
);
    import slt_pkg::*;

    logic [NUM_REFS-1:0][STEP_W-1:0] r_step;
    logic [NUM_REFS-1:0][REF_W-1:0]  r_acc, n_acc;
    logic [NUM_REFS-1:0][REF_W-1:0]  r_lat, n_lat;

    always_comb begin
        for (int i = 0; i < NUM_REFS; i++) begin
            n_acc[i] = r_acc[i];
            n_lat[i] = r_lat[i];
            if (i_ctl.write && (i_word.ref_select == 2'(i))) begin
                if (i_word.hi_half) begin
                    // upper half keeps 12 bits, bit 27 is the sign
                    n_lat[i] = {i_word.write_value[11:0], r_lat[i][15:0]};
                    n_acc[i] = {i_word.write_value[11:0], r_acc[i][15:0]};
                end else begin
                    n_lat[i] = {r_lat[i][REF_W-1:16], i_word.write_value};
                    n_acc[i] = {r_acc[i][REF_W-1:16], i_word.write_value};
                end
            end else if (i_ctl.step) begin
                n_acc[i] = r_acc[i] + {{(REF_W-STEP_W){r_step[i][STEP_W-1]}}, r_step[i]};
            end else if (i_ctl.reload) begin
                n_acc[i] = r_lat[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= {STEP_Y_RESET, STEP_X_RESET, STEP_Y_RESET, STEP_X_RESET};
            r_acc  <= '0;
            r_lat  <= '0;
        end else begin
            if (i_acc) begin
                r_acc <= n_acc;
                r_lat <= n_lat;
            end
            if (i_cfg_wr) begin
                case (i_cfg_idx)
                    CFG_BG2_DX: r_step[0] <= i_cfg_data;
                    CFG_BG2_DY: r_step[1] <= i_cfg_data;
                    CFG_BG3_DX: r_step[2] <= i_cfg_data;
                    CFG_BG3_DY: r_step[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_ref = n_acc;

endmodule

>>> sv/slt_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_obuf
// Result register with a skid stage, so a word can be taken in while the
// previous result waits.
// ----------------------------------------------------------------------------
module slt_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  slt_pkg::t_out_word i_word,
    output logic               o_ready,
    output logic               o_valid,
    output slt_pkg::t_out_word o_word,
    input  logic               i_ready
);
    import slt_pkg::*;

    logic      r_out_vld;
    logic      r_skd_vld;
    t_out_word r_out;
    t_out_word r_skd;
    logic      take;

    assign take    = !r_out_vld || i_ready;
    assign o_ready = i_rst_n && !r_skd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (take) begin
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= i_valid;
            end
        end else if (i_valid) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skd_vld) begin
                r_out <= r_skd;
            end else if (i_valid) begin
                r_out <= i_word;
            end
        end else if (i_valid) begin
            r_skd <= i_word;
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

endmodule

>>> sv/slt_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_check
// Port-level checks on the scanline timing block, bound to the top level.
// ----------------------------------------------------------------------------
module slt_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input slt_pkg::t_out_word i_out_data
);
    import slt_pkg::*;

    // after an accepted word, o_out is always valid the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after accepted word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.line < LINE_WRAP)
        else $error("line out of range");

    // write words carry no pulses or events; blank pulses only with their flag
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_data.period_cycles != 10'd0 ||
             (i_out_data.irq_pulses == 3'd0 && i_out_data.events == 4'd0)) &&
            ((i_out_data.irq_pulses[1:0] & ~i_out_data.status_flags[1:0]) == 2'd0))
        else $error("pulse without period change or flag");

endmodule

bind scanline_timing_and_affine_refs slt_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
